>>> rtl/qpde_pkg.sv
// ----------------------------------------------------------------------------
// Quintic polynomial derivative evaluator package
// Shared word types, register indexes, derivative weights and the Q16.16
// saturation helper used by the pipeline stages.
// ----------------------------------------------------------------------------
package qpde_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_COEF_0    = 3'd0;
	localparam logic [2:0] REG_COEF_1    = 3'd1;
	localparam logic [2:0] REG_COEF_2    = 3'd2;
	localparam logic [2:0] REG_COEF_3    = 3'd3;
	localparam logic [2:0] REG_COEF_4    = 3'd4;
	localparam logic [2:0] REG_COEF_5    = 3'd5;
	localparam logic [2:0] REG_END_TIME  = 3'd6;
	localparam logic [2:0] REG_END_LEVEL = 3'd7;

	// Highest derivative order that produces a polynomial result.
	localparam logic [2:0] MAX_ORDER = 3'd5;

	// Input word: evaluation time and derivative order.
	typedef struct packed {
		logic signed [31:0] time_point;
		logic [2:0]         mode;
	} in_word_t;

	// Output word: saturated result and clip flag.
	typedef struct packed {
		logic signed [31:0] value;
		logic               saturated;
	} out_word_t;

	// Word travelling down the Horner pipeline.
	typedef struct packed {
		logic               vld;
		logic [2:0]         n;
		logic signed [31:0] t;
		logic signed [31:0] acc;
		logic               flag;
		logic               byp;
		logic signed [31:0] byp_val;
	} pipe_t;

	// Saturated value together with a flag that says whether it clipped.
	typedef struct packed {
		logic               clip;
		logic signed [31:0] val;
	} sat_t;

	// Clip a wide signed value to the signed 32-bit range.
	function automatic sat_t sat32(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.clip = 1'b1;
			r.val  = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r.clip = 1'b1;
			r.val  = 32'sh80000000;
		end else begin
			r.clip = 1'b0;
			r.val  = v[31:0];
		end
		return r;
	endfunction

	// Derivative weight i!/(i-n)! for order n and term i, zero below the order.
	function automatic logic [7:0] weight(input logic [2:0] n, input logic [2:0] i);
		logic [7:0] w;
		w = 8'd0;
		unique case (n)
			3'd0: w = (i <= 3'd5) ? 8'd1 : 8'd0;
			3'd1: begin
				unique case (i)
					3'd1: w = 8'd1;
					3'd2: w = 8'd2;
					3'd3: w = 8'd3;
					3'd4: w = 8'd4;
					3'd5: w = 8'd5;
					default: w = 8'd0;
				endcase
			end
			3'd2: begin
				unique case (i)
					3'd2: w = 8'd2;
					3'd3: w = 8'd6;
					3'd4: w = 8'd12;
					3'd5: w = 8'd20;
					default: w = 8'd0;
				endcase
			end
			3'd3: begin
				unique case (i)
					3'd3: w = 8'd6;
					3'd4: w = 8'd24;
					3'd5: w = 8'd60;
					default: w = 8'd0;
				endcase
			end
			3'd4: begin
				unique case (i)
					3'd4: w = 8'd24;
					3'd5: w = 8'd120;
					default: w = 8'd0;
				endcase
			end
			3'd5: w = (i == 3'd5) ? 8'd120 : 8'd0;
			default: w = 8'd0;
		endcase
		return w;
	endfunction

endpackage

>>> rtl/qpde_step.sv
// ----------------------------------------------------------------------------
// Horner step
// One Horner iteration in two register stages: the first forms acc * t and
// the weighted coefficient, the second rounds, adds and saturates. Terms
// below the item's derivative order pass the word through unchanged.
// ----------------------------------------------------------------------------
module qpde_step #(
	parameter int unsigned IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en_down,
	output logic               en_up,
	input  qpde_pkg::pipe_t    up,
	input  logic signed [31:0] coef,
	output qpde_pkg::pipe_t    down
);

	localparam logic [2:0] IDX3 = 3'(IDX);

	qpde_pkg::pipe_t    mul_s1;
	logic signed [63:0] prod_s1;
	qpde_pkg::sat_t     wsat_s1;
	logic               act_s1;
	qpde_pkg::pipe_t    add_s2;

	logic               en_mul;
	logic               en_add;
	logic signed [63:0] prod_c;
	logic signed [39:0] wprod_c;
	logic [7:0]         w8_c;
	logic signed [63:0] rnd_c;
	logic signed [63:0] shr_c;
	qpde_pkg::sat_t     psat_c;
	logic signed [32:0] sum_c;
	qpde_pkg::sat_t     ssat_c;
	qpde_pkg::pipe_t    nxt_c;

	// A stage loads when it is empty or the stage after it moves.
	assign en_add = ~add_s2.vld | en_down;
	assign en_mul = ~mul_s1.vld | en_add;
	assign en_up  = en_mul;

	// Multiply stage: exact Q32.32 product and weighted coefficient.
	assign prod_c  = up.acc * up.t;
	assign w8_c    = qpde_pkg::weight(up.n, IDX3);
	assign wprod_c = coef * $signed({1'b0, w8_c});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s1.vld <= 1'b0;
		end else if (en_mul) begin
			mul_s1  <= up;
			prod_s1 <= prod_c;
			wsat_s1 <= qpde_pkg::sat32(64'(wprod_c));
			act_s1  <= (up.n <= IDX3);
		end
	end

	// Add stage: round half up to Q16.16, saturate, add and saturate again.
	assign rnd_c  = prod_s1 + 64'sd32768;
	assign shr_c  = rnd_c >>> 16;
	assign psat_c = qpde_pkg::sat32(shr_c);
	assign sum_c  = 33'(psat_c.val) + 33'(wsat_s1.val);
	assign ssat_c = qpde_pkg::sat32(64'(sum_c));

	always_comb begin
		nxt_c = mul_s1;
		if (act_s1) begin
			nxt_c.acc  = ssat_c.val;
			nxt_c.flag = mul_s1.flag | wsat_s1.clip | psat_c.clip | ssat_c.clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s2.vld <= 1'b0;
		end else if (en_add) begin
			add_s2 <= nxt_c;
		end
	end

	assign down = add_s2;

endmodule

>>> rtl/quintic_poly_derivative_eval.sv
// ----------------------------------------------------------------------------
// Quintic polynomial derivative evaluator
// Evaluates a Q16.16 quintic or one of its first five derivatives in Horner
// form, with saturation and a clip flag.
// ----------------------------------------------------------------------------
// Usage:
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes the six coefficients, the end time and the end level; it is
//   always ready and should be used only while no word is in flight.
//   The input channel takes one word per cycle (time point and derivative
//   order) when in_valid is high and in_stall is low. Each input word gives
//   exactly one output word on out_valid / out_stall, in order.
//   The pipeline holds one entry stage, five Horner steps of two stages
//   each (multiply, then round and add), and the output register.
//   Throughput is one word per cycle while out_stall is low. When the
//   receiver stalls, words collect in empty stages and in_stall rises
//   only once the pipeline is full; nothing is lost or repeated. Reset
//   clears all valid bits and sets the configuration registers to zero.
// ----------------------------------------------------------------------------
module quintic_poly_derivative_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  qpde_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output qpde_pkg::out_word_t out_data
);

	logic signed [31:0]  coef_q [0:5];
	logic signed [31:0]  end_time_q;
	logic signed [31:0]  end_level_q;

	qpde_pkg::pipe_t     entry_s1;
	qpde_pkg::pipe_t     entry_c;
	qpde_pkg::pipe_t     chain [0:5];
	logic                en_c [0:5];
	logic                en_entry;
	logic signed [39:0]  w5prod_c;
	qpde_pkg::sat_t      w5sat_c;

	logic                out_valid_q;
	qpde_pkg::out_word_t out_q;
	logic                en_out;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) begin
				coef_q[k] <= '0;
			end
			end_time_q  <= '0;
			end_level_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				qpde_pkg::REG_COEF_0:    coef_q[0]   <= cfg_data;
				qpde_pkg::REG_COEF_1:    coef_q[1]   <= cfg_data;
				qpde_pkg::REG_COEF_2:    coef_q[2]   <= cfg_data;
				qpde_pkg::REG_COEF_3:    coef_q[3]   <= cfg_data;
				qpde_pkg::REG_COEF_4:    coef_q[4]   <= cfg_data;
				qpde_pkg::REG_COEF_5:    coef_q[5]   <= cfg_data;
				qpde_pkg::REG_END_TIME:  end_time_q  <= cfg_data;
				qpde_pkg::REG_END_LEVEL: end_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Entry stage: classify the word and seed the accumulator with W(5).
	assign w5prod_c = coef_q[5] * $signed({1'b0, qpde_pkg::weight(in_data.mode, 3'd5)});
	assign w5sat_c  = qpde_pkg::sat32(64'(w5prod_c));

	always_comb begin
		entry_c.vld     = in_valid;
		entry_c.n       = in_data.mode;
		entry_c.t       = in_data.time_point;
		entry_c.acc     = w5sat_c.val;
		entry_c.flag    = w5sat_c.clip;
		entry_c.byp     = 1'b0;
		entry_c.byp_val = '0;
		if (in_data.mode > qpde_pkg::MAX_ORDER) begin
			entry_c.byp = 1'b1;
		end else if (in_data.time_point >= end_time_q) begin
			entry_c.byp = 1'b1;
			if (in_data.mode == 3'd0) begin
				entry_c.byp_val = end_level_q;
			end
		end
	end

	assign en_entry = ~entry_s1.vld | en_c[0];
	assign in_stall = ~en_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_s1.vld <= 1'b0;
		end else if (en_entry) begin
			entry_s1 <= entry_c;
		end
	end

	assign chain[0] = entry_s1;

	// Horner steps for terms four down to zero.
	for (genvar k = 0; k < 5; k++) begin : g_step
		qpde_step #(
			.IDX (4 - k)
		) u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en_down (en_c[k + 1]),
			.en_up   (en_c[k]),
			.up      (chain[k]),
			.coef    (coef_q[4 - k]),
			.down    (chain[k + 1])
		);
	end

	// Output register: pick the bypass value or the Horner result.
	assign en_out   = ~out_valid_q | ~out_stall;
	assign en_c[5]  = en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= chain[5].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			if (chain[5].byp) begin
				out_q.value     <= chain[5].byp_val;
				out_q.saturated <= 1'b0;
			end else begin
				out_q.value     <= chain[5].acc;
				out_q.saturated <= chain[5].flag;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
